// ===== hdl/mhpq_pkg.sv =====
// Shared types and status codes of the max-heap priority queue.
package mhpq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 8;
  localparam int unsigned STAT_W = 2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] value;
  } mhpq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] max_value;
    logic                     max_valid;
    logic [OCC_W-1:0]         occupancy;
    logic [STAT_W-1:0]        status;
  } mhpq_out_t;

endpackage

// ===== hdl/mhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/max_heap_priority_queue.sv =====
// Top level of the binary max-heap priority queue with its sift sequencer.
// Usage: drive in_item and raise start; the transaction is taken at the rising
// edge where start is high and busy is low. mode 0 pushes in_item.value, mode 1
// pops the maximum. Each transaction gives exactly one result, shown on
// out_item for a single cycle with out_valid high; the receiver cannot stall.
// A push on a full heap, a pop on an empty heap and a pop that leaves the heap
// empty answer straight from idle, with no walk. A push walks up the tree,
// reading the parent and then comparing at each level. A pop fetches the last
// entry, then walks down, reading and comparing the left and, if present, the
// right child at each level. The single RAM port
// pair and one shared signed comparator set this pace; busy stays high
// until the result is shown, and a new transaction may be taken in the same
// cycle the result appears, so transactions are spaced by their latency.
// Reset (rst_n low, synchronous) empties the heap and returns to idle; the
// heap RAM is not cleared, as entries are only read below the occupancy.
// The root is shadowed in a register so the maximum needs no final read.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mhpq_in_t  in_item,
  output logic      out_valid,
  output mhpq_out_t out_item
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UP   = 6'b000010,
    S_UPC  = 6'b000100,
    S_LAST = 6'b001000,
    S_DNL  = 6'b010000,
    S_DNCL = 6'b100000
  } state_t;

  // Right-child compare has its own flag to keep the enum narrow to the walk.
  state_t            state_r, state_nxt;
  logic              dncr_r, dncr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [DATA_W-1:0] v_r, v_nxt;
  logic [DATA_W-1:0] bval_r, bval_nxt;
  logic [AW-1:0]     bidx_r, bidx_nxt;
  logic              bmov_r, bmov_nxt;
  logic [DATA_W-1:0] popped_r, popped_nxt;
  logic [DATA_W-1:0] root_r, root_nxt;
  logic              out_valid_r, out_valid_nxt;
  mhpq_out_t         out_r, out_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  logic [DATA_W-1:0] cmp_a, cmp_b;
  logic              cmp_gt;

  logic [IW-1:0]     l_w, r_w, cnt_w;
  logic [AW-1:0]     parent;
  logic              accept;
  logic              finish;
  logic              fin_mov;
  logic [DATA_W-1:0] fin_val;
  logic [AW-1:0]     fin_idx;

  mhpq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (we),
    .wr_addr(waddr),
    .wr_data(wdata),
    .rd_addr(raddr),
    .rd_data(rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign l_w    = IW'({pos_r, 1'b1});
  assign r_w    = l_w + IW'(1);
  assign cnt_w  = IW'(count_r);
  assign parent = AW'((pos_r - AW'(1)) >> 1);

  // Shared signed comparator: operands follow the step in progress.
  always_comb begin
    cmp_a = rdata;
    cmp_b = v_r;
    if (state_r == S_UPC) begin
      cmp_a = v_r;
      cmp_b = rdata;
    end else if (dncr_r) begin
      cmp_a = rdata;
      cmp_b = bval_r;
    end
  end
  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  // Best of parent, left and right children after the current compare.
  always_comb begin
    if (dncr_r) begin
      fin_mov = cmp_gt || bmov_r;
      fin_val = cmp_gt ? rdata : bval_r;
      fin_idx = cmp_gt ? r_w[AW-1:0] : bidx_r;
    end else begin
      fin_mov = cmp_gt;
      fin_val = cmp_gt ? rdata : v_r;
      fin_idx = cmp_gt ? l_w[AW-1:0] : pos_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    dncr_nxt      = 1'b0;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    v_nxt         = v_r;
    bval_nxt      = bval_r;
    bidx_nxt      = bidx_r;
    bmov_nxt      = bmov_r;
    popped_nxt    = popped_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = v_r;
    raddr         = parent;
    finish        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.mode == MODE_PUSH) begin
            if (count_r == CW'(CAPACITY)) begin
              // Reject: heap stays as it is.
              out_valid_nxt        = 1'b1;
              out_nxt.popped_value = '0;
              out_nxt.max_value    = root_r;
              out_nxt.max_valid    = 1'b1;
              out_nxt.occupancy    = OCC_W'(count_r);
              out_nxt.status       = STAT_FULL;
            end else begin
              v_nxt      = in_item.value;
              pos_nxt    = AW'(count_r);
              count_nxt  = count_r + CW'(1);
              popped_nxt = '0;
              state_nxt  = S_UP;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt        = 1'b1;
              out_nxt.popped_value = '0;
              out_nxt.max_value    = '0;
              out_nxt.max_valid    = 1'b0;
              out_nxt.occupancy    = '0;
              out_nxt.status       = STAT_EMPTY;
            end else if (count_r == CW'(1)) begin
              count_nxt            = '0;
              out_valid_nxt        = 1'b1;
              out_nxt.popped_value = root_r;
              out_nxt.max_value    = '0;
              out_nxt.max_valid    = 1'b0;
              out_nxt.occupancy    = '0;
              out_nxt.status       = STAT_DONE;
            end else begin
              // Fetch the last entry; it becomes the hole value at the root.
              raddr      = AW'(count_r - CW'(1));
              count_nxt  = count_r - CW'(1);
              popped_nxt = root_r;
              state_nxt  = S_LAST;
            end
          end
        end
      end

      S_UP: begin
        if (pos_r == '0) begin
          we     = 1'b1;
          finish = 1'b1;
        end else begin
          raddr     = parent;
          state_nxt = S_UPC;
        end
      end

      S_UPC: begin
        we = 1'b1;
        if (cmp_gt) begin
          // Move the parent down into the hole and climb.
          wdata     = rdata;
          pos_nxt   = parent;
          state_nxt = S_UP;
        end else begin
          finish = 1'b1;
        end
      end

      S_LAST: begin
        v_nxt     = rdata;
        pos_nxt   = '0;
        state_nxt = S_DNL;
      end

      S_DNL: begin
        if (l_w >= cnt_w) begin
          we     = 1'b1;
          finish = 1'b1;
        end else begin
          raddr     = l_w[AW-1:0];
          state_nxt = S_DNCL;
        end
      end

      S_DNCL: begin
        if (!dncr_r && (r_w < cnt_w)) begin
          // Hold the left result and fetch the right child.
          bval_nxt = fin_val;
          bidx_nxt = fin_idx;
          bmov_nxt = fin_mov;
          raddr    = r_w[AW-1:0];
          dncr_nxt = 1'b1;
        end else begin
          we = 1'b1;
          if (fin_mov) begin
            wdata     = fin_val;
            pos_nxt   = fin_idx;
            state_nxt = S_DNL;
          end else begin
            finish = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    root_nxt = (we && (waddr == '0)) ? wdata : root_r;

    if (finish) begin
      state_nxt            = S_IDLE;
      out_valid_nxt        = 1'b1;
      out_nxt.popped_value = popped_r;
      out_nxt.max_value    = root_nxt;
      out_nxt.max_valid    = 1'b1;
      out_nxt.occupancy    = OCC_W'(count_r);
      out_nxt.status       = STAT_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dncr_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dncr_r      <= dncr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    v_r      <= v_nxt;
    bval_r   <= bval_nxt;
    bidx_r   <= bidx_nxt;
    bmov_r   <= bmov_nxt;
    popped_r <= popped_nxt;
    root_r   <= root_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
